FILE: hdl/bqd_pkg.sv
// ----------------------------------------------------------------------------
// bqd_pkg: shared types and constants for the biquad cascade decimator
// Section coefficients, sequencer states and the datapath control word.
// ----------------------------------------------------------------------------
`default_nettype none

package bqd_pkg;

  localparam int SECTION_COUNT = 5;
  localparam int SAMPLE_WIDTH  = 32;

  localparam int STATE_W   = 40;
  localparam int COEF_W    = 22;
  localparam int COEF_FRAC = 20;
  localparam int ACC_W     = 64;

  localparam int DECIM_W   = 4;
  localparam int HOP_W     = 13;
  localparam int HOP_POS_W = 12;
  localparam int PHASE_W   = 3;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [DECIM_W-1:0] DECIM_RST = 4'd4;
  localparam logic [DECIM_W-1:0] DECIM_MAX = 4'd8;
  localparam logic [HOP_W-1:0]   HOP_RST   = 13'd256;
  localparam logic [HOP_W-1:0]   HOP_MAX   = 13'd4096;

  typedef enum logic {
    REG_DECIM = 1'b0,
    REG_HOP   = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_MA1,
    ST_MA2,
    ST_T,
    ST_TR,
    ST_U1,
    ST_U2,
    ST_UR,
    ST_G,
    ST_GA,
    ST_XR,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    CS_B1,
    CS_A1,
    CS_A2,
    CS_GAIN
  } coef_sel_e;

  typedef enum logic [1:0] {
    OPA_W0,
    OPA_W1,
    OPA_U
  } opa_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    ADD_X,
    ADD_T,
    ADD_W1,
    ADD_PROD
  } add_sel_e;

  typedef enum logic [1:0] {
    RND_NONE,
    RND_T,
    RND_U,
    RND_X
  } rnd_dst_e;

  typedef struct packed {
    logic                      load_x;
    logic                      cap_w0;
    logic                      cap_w1;
    logic                      mul_en;
    opa_e                      opa;
    logic signed [COEF_W-1:0]  coef;
    acc_op_e                   acc_op;
    add_sel_e                  add_sel;
    rnd_dst_e                  rnd_dst;
    logic                      wsel_t;
  } dp_ctrl_t;

  // Q2.20 low-pass coefficients; sections past the table reuse the last one
  function automatic logic signed [COEF_W-1:0] coef_lookup(input int unsigned sec,
                                                           input coef_sel_e   sel);
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    case (sec)
      0: begin
        b1 = 22'sd1257059;  a1 = -22'sd1515472; a2 = 22'sd572939;
      end
      1: begin
        b1 = -22'sd595026;  a1 = -22'sd1496024; a2 = 22'sd715143;
      end
      2: begin
        b1 = -22'sd1152449; a1 = -22'sd1476662; a2 = 22'sd868920;
      end
      3: begin
        b1 = -22'sd1327336; a1 = -22'sd1468960; a2 = 22'sd968918;
      end
      default: begin
        b1 = -22'sd1382913; a1 = -22'sd1476649; a2 = 22'sd1026532;
      end
    endcase
    case (sel)
      CS_B1:   return b1;
      CS_A1:   return a1;
      CS_A2:   return a2;
      default: return 22'sd282333;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: hdl/biquad_cascade_decimator.sv
// One word is filtered at a time: in_ready_o is high only in the idle state, so a new
// word waits until the last has passed through the single shared
// multiply-accumulate unit stepping through 12 operations per section.
// Reset: rst_ni clears control, counters, state valid bits and registers to
// decimation_factor=4, hop_length=256; section states read as zero until written.
// ----------------------------------------------------------------------------
// biquad_cascade_decimator: biquad low-pass cascade with hop-aligned decimation
// Direct-form-II sections in Q.8 with 40-bit states, one shared MAC under a
// sequencer, APB configuration and an output register toward the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_cascade_decimator #(
  parameter int SECTION_COUNT = bqd_pkg::SECTION_COUNT,
  parameter int SAMPLE_WIDTH  = bqd_pkg::SAMPLE_WIDTH
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed      [SAMPLE_WIDTH-1:0]       filtered_sample_o,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [bqd_pkg::PADDR_W-1:0]          paddr,
  input  wire logic [bqd_pkg::PDATA_W-1:0]          pwdata,
  output logic      [bqd_pkg::PDATA_W-1:0]          prdata,
  output logic                                      pready
);

  localparam int StW   = bqd_pkg::STATE_W;
  localparam int SW    = SAMPLE_WIDTH;
  localparam int Depth = 2 * SECTION_COUNT;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SecW  = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
  localparam int XW    = (SW > StW) ? SW : StW;
  localparam int YW    = (SW < StW) ? StW : SW;
  localparam int DecW  = bqd_pkg::DECIM_W;
  localparam int HopW  = bqd_pkg::HOP_W;
  localparam int PosW  = bqd_pkg::HOP_POS_W;
  localparam int PhW   = bqd_pkg::PHASE_W;
  localparam int PdW   = bqd_pkg::PDATA_W;

  bqd_pkg::state_e state_q, state_d;
  logic [SecW-1:0]  sec_q, sec_d;
  logic             emit_q;
  logic [DecW-1:0]  dec_q;
  logic [HopW-1:0]  hop_q;
  logic [PosW-1:0]  hop_pos_q;
  logic [PhW-1:0]   phase_q;
  logic             out_valid_q;
  logic [SW-1:0]    out_data_q;
  logic [Depth-1:0] dval_q;
  logic             rvld_q;

  bqd_pkg::dp_ctrl_t  ctrl;
  bqd_pkg::coef_sel_e csel;
  logic               in_acc;
  logic               out_load;
  logic               mem_we;
  logic [AddrW-1:0]   waddr, raddr;
  logic [StW-1:0]     mem_wdata, mem_rdata, rdata_m;
  logic signed [StW-1:0] x0, x_cur;
  logic signed [XW-1:0]  s_ext;
  logic [XW-StW:0]       s_top;
  logic signed [YW-1:0]  y_ext;
  logic [YW-SW:0]        y_top;
  logic [SW-1:0]         y_sat;
  logic                  apb_wr;
  logic [DecW-1:0]       fac_eff;
  logic [HopW-1:0]       hop_eff;
  logic [DecW-1:0]       phase_inc;
  logic [HopW-1:0]       pos_inc;

  // ---------------- configuration port
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q <= bqd_pkg::DECIM_RST;
      hop_q <= bqd_pkg::HOP_RST;
    end else if (apb_wr) begin
      case (bqd_pkg::reg_idx_e'(paddr[2]))
        bqd_pkg::REG_DECIM: dec_q <= pwdata[DecW-1:0];
        bqd_pkg::REG_HOP:   hop_q <= pwdata[HopW-1:0];
        default:            dec_q <= dec_q;
      endcase
    end
  end

  always_comb begin
    case (bqd_pkg::reg_idx_e'(paddr[2]))
      bqd_pkg::REG_DECIM: prdata = PdW'(dec_q);
      bqd_pkg::REG_HOP:   prdata = PdW'(hop_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------- hop and decimation counters
  always_comb begin
    if (dec_q == '0) begin
      fac_eff = DecW'(1);
    end else if (dec_q > bqd_pkg::DECIM_MAX) begin
      fac_eff = bqd_pkg::DECIM_MAX;
    end else begin
      fac_eff = dec_q;
    end
    if (hop_q == '0) begin
      hop_eff = HopW'(1);
    end else if (hop_q > bqd_pkg::HOP_MAX) begin
      hop_eff = bqd_pkg::HOP_MAX;
    end else begin
      hop_eff = hop_q;
    end
    phase_inc = DecW'(phase_q) + DecW'(1);
    pos_inc   = HopW'(hop_pos_q) + HopW'(1);
  end

  assign in_acc = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_pos_q <= '0;
      phase_q   <= '0;
      emit_q    <= 1'b0;
    end else if (in_acc) begin
      emit_q <= (phase_q == '0);
      if (pos_inc >= hop_eff) begin
        hop_pos_q <= '0;
        phase_q   <= '0;
      end else begin
        hop_pos_q <= pos_inc[PosW-1:0];
        phase_q   <= (phase_inc >= fac_eff) ? '0 : phase_inc[PhW-1:0];
      end
    end
  end

  // ---------------- input clamp to the state range
  always_comb begin
    s_ext = XW'(sample_i);
    s_top = s_ext[XW-1:StW-1];
    if ((&s_top) || !(|s_top)) begin
      x0 = s_ext[StW-1:0];
    end else if (s_ext[XW-1]) begin
      x0 = {1'b1, {(StW-1){1'b0}}};
    end else begin
      x0 = {1'b0, {(StW-1){1'b1}}};
    end
  end

  // ---------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bqd_pkg::ST_IDLE;
      sec_q   <= '0;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    sec_d        = sec_q;
    in_ready_o   = 1'b0;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    raddr        = AddrW'({sec_q, 1'b0});
    waddr        = AddrW'({sec_q, 1'b0});
    csel         = bqd_pkg::CS_A1;
    ctrl         = '0;
    ctrl.opa     = bqd_pkg::OPA_W0;
    ctrl.acc_op  = bqd_pkg::ACC_HOLD;
    ctrl.add_sel = bqd_pkg::ADD_PROD;
    ctrl.rnd_dst = bqd_pkg::RND_NONE;
    case (state_q)
      bqd_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl.load_x = in_valid_i;
        if (in_valid_i) begin
          sec_d   = '0;
          state_d = bqd_pkg::ST_RD0;
        end
      end
      bqd_pkg::ST_RD0: begin
        state_d = bqd_pkg::ST_RD1;
      end
      bqd_pkg::ST_RD1: begin
        raddr        = AddrW'({sec_q, 1'b1});
        ctrl.cap_w0  = 1'b1;
        ctrl.acc_op  = bqd_pkg::ACC_LOAD;
        ctrl.add_sel = bqd_pkg::ADD_X;
        state_d      = bqd_pkg::ST_MA1;
      end
      bqd_pkg::ST_MA1: begin
        ctrl.cap_w1 = 1'b1;
        ctrl.mul_en = 1'b1;
        ctrl.opa    = bqd_pkg::OPA_W0;
        csel        = bqd_pkg::CS_A1;
        state_d     = bqd_pkg::ST_MA2;
      end
      bqd_pkg::ST_MA2: begin
        ctrl.mul_en = 1'b1;
        ctrl.opa    = bqd_pkg::OPA_W1;
        csel        = bqd_pkg::CS_A2;
        ctrl.acc_op = bqd_pkg::ACC_SUB;
        state_d     = bqd_pkg::ST_T;
      end
      bqd_pkg::ST_T: begin
        ctrl.mul_en = 1'b1;
        ctrl.opa    = bqd_pkg::OPA_W0;
        csel        = bqd_pkg::CS_B1;
        ctrl.acc_op = bqd_pkg::ACC_SUB;
        state_d     = bqd_pkg::ST_TR;
      end
      bqd_pkg::ST_TR: begin
        ctrl.rnd_dst = bqd_pkg::RND_T;
        ctrl.acc_op  = bqd_pkg::ACC_LOAD;
        state_d      = bqd_pkg::ST_U1;
      end
      bqd_pkg::ST_U1: begin
        ctrl.acc_op  = bqd_pkg::ACC_ADD;
        ctrl.add_sel = bqd_pkg::ADD_T;
        mem_we       = 1'b1;
        waddr        = AddrW'({sec_q, 1'b1});
        state_d      = bqd_pkg::ST_U2;
      end
      bqd_pkg::ST_U2: begin
        ctrl.acc_op  = bqd_pkg::ACC_ADD;
        ctrl.add_sel = bqd_pkg::ADD_W1;
        ctrl.wsel_t  = 1'b1;
        mem_we       = 1'b1;
        state_d      = bqd_pkg::ST_UR;
      end
      bqd_pkg::ST_UR: begin
        ctrl.rnd_dst = bqd_pkg::RND_U;
        state_d      = bqd_pkg::ST_G;
      end
      bqd_pkg::ST_G: begin
        ctrl.mul_en = 1'b1;
        ctrl.opa    = bqd_pkg::OPA_U;
        csel        = bqd_pkg::CS_GAIN;
        state_d     = bqd_pkg::ST_GA;
      end
      bqd_pkg::ST_GA: begin
        ctrl.acc_op = bqd_pkg::ACC_LOAD;
        state_d     = bqd_pkg::ST_XR;
      end
      bqd_pkg::ST_XR: begin
        ctrl.rnd_dst = bqd_pkg::RND_X;
        if (sec_q == SecW'(SECTION_COUNT - 1)) begin
          state_d = bqd_pkg::ST_DONE;
        end else begin
          sec_d   = sec_q + SecW'(1);
          state_d = bqd_pkg::ST_RD0;
        end
      end
      bqd_pkg::ST_DONE: begin
        if (!emit_q) begin
          state_d = bqd_pkg::ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = bqd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bqd_pkg::ST_IDLE;
      end
    endcase
    ctrl.coef = bqd_pkg::coef_lookup(int'(sec_q), csel);
  end

  // ---------------- section state memory, zero until written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dval_q <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        dval_q[waddr] <= 1'b1;
      end
      rvld_q <= dval_q[raddr];
    end
  end

  bqd_ram #(
    .Width (StW),
    .Depth (Depth)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (mem_wdata),
    .raddr_i (raddr),
    .rdata_o (mem_rdata)
  );

  assign rdata_m = rvld_q ? mem_rdata : '0;

  bqd_mac u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .x0_i    (x0),
    .rdata_i (rdata_m),
    .x_o     (x_cur),
    .wdata_o (mem_wdata)
  );

  // ---------------- output clamp and register
  always_comb begin
    y_ext = YW'(x_cur);
    y_top = y_ext[YW-1:SW-1];
    if ((&y_top) || !(|y_top)) begin
      y_sat = y_ext[SW-1:0];
    end else if (y_ext[YW-1]) begin
      y_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= y_sat;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign filtered_sample_o = out_data_q;

`ifndef SYNTH
  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bqd_pkg::ST_DONE && emit_q && (!out_valid_q || out_ready_i))
      |=> out_valid_o)
    else $error("kept word not presented at output");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == bqd_pkg::ST_RD0 && sec_q == '0))
    else $error("accepted word did not start at first section");

  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != bqd_pkg::ST_IDLE |-> sec_q <= SecW'(SECTION_COUNT - 1))
    else $error("section index out of range");
`endif

endmodule

`default_nettype wire

FILE: hdl/bqd_ram.sv
// ----------------------------------------------------------------------------
// bqd_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_ram #(
  parameter int Width = 40,
  parameter int Depth = 10
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                        wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/bqd_mac.sv
// ----------------------------------------------------------------------------
// bqd_mac: shared multiply-accumulate unit of the biquad cascade
// One registered 40x22 multiplier, a 64-bit accumulator and one
// round-half-up / saturate stage back to the 40-bit state range.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_mac (
  input  wire logic                                   clk_i,
  input  wire bqd_pkg::dp_ctrl_t                      ctrl_i,
  input  wire logic signed [bqd_pkg::STATE_W-1:0]     x0_i,
  input  wire logic signed [bqd_pkg::STATE_W-1:0]     rdata_i,
  output logic signed      [bqd_pkg::STATE_W-1:0]     x_o,
  output logic signed      [bqd_pkg::STATE_W-1:0]     wdata_o
);

  localparam int StW  = bqd_pkg::STATE_W;
  localparam int CfW  = bqd_pkg::COEF_W;
  localparam int AccW = bqd_pkg::ACC_W;
  localparam int Frac = bqd_pkg::COEF_FRAC;
  localparam int MulW = StW + CfW;
  localparam logic signed [AccW-1:0] Half = AccW'(1) <<< (Frac - 1);

  logic signed [StW-1:0]  w0_q, w1_q, t_q, u_q, x_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [AccW-1:0] prod_q;
  logic signed [StW-1:0]  opa;
  logic signed [MulW-1:0] mul;
  logic signed [AccW-1:0] addend;
  logic signed [AccW-1:0] rnd_sum;
  logic signed [AccW-1:0] rnd_shr;
  logic signed [StW-1:0]  rnd_sat;
  logic [AccW-StW:0]      rnd_top;

  always_comb begin
    case (ctrl_i.opa)
      bqd_pkg::OPA_W0: opa = w0_q;
      bqd_pkg::OPA_W1: opa = w1_q;
      bqd_pkg::OPA_U:  opa = u_q;
      default:         opa = w0_q;
    endcase
    mul = opa * ctrl_i.coef;
  end

  always_comb begin
    case (ctrl_i.add_sel)
      bqd_pkg::ADD_X:    addend = AccW'(x_q) <<< Frac;
      bqd_pkg::ADD_T:    addend = AccW'(t_q) <<< Frac;
      bqd_pkg::ADD_W1:   addend = AccW'(w1_q) <<< Frac;
      bqd_pkg::ADD_PROD: addend = prod_q;
      default:           addend = prod_q;
    endcase
    case (ctrl_i.acc_op)
      bqd_pkg::ACC_HOLD: acc_d = acc_q;
      bqd_pkg::ACC_LOAD: acc_d = addend;
      bqd_pkg::ACC_ADD:  acc_d = acc_q + addend;
      bqd_pkg::ACC_SUB:  acc_d = acc_q - addend;
      default:           acc_d = acc_q;
    endcase
  end

  // round half up to Q.8, then clamp to the state range
  always_comb begin
    rnd_sum = acc_q + Half;
    rnd_shr = rnd_sum >>> Frac;
    rnd_top = rnd_shr[AccW-1:StW-1];
    if ((&rnd_top) || !(|rnd_top)) begin
      rnd_sat = rnd_shr[StW-1:0];
    end else if (rnd_shr[AccW-1]) begin
      rnd_sat = {1'b1, {(StW-1){1'b0}}};
    end else begin
      rnd_sat = {1'b0, {(StW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctrl_i.mul_en) begin
      prod_q <= AccW'(mul);
    end
    if (ctrl_i.cap_w0) begin
      w0_q <= rdata_i;
    end
    if (ctrl_i.cap_w1) begin
      w1_q <= rdata_i;
    end
    if (ctrl_i.load_x) begin
      x_q <= x0_i;
    end else if (ctrl_i.rnd_dst == bqd_pkg::RND_X) begin
      x_q <= rnd_sat;
    end
    if (ctrl_i.rnd_dst == bqd_pkg::RND_T) begin
      t_q <= rnd_sat;
    end
    if (ctrl_i.rnd_dst == bqd_pkg::RND_U) begin
      u_q <= rnd_sat;
    end
  end

  assign x_o     = x_q;
  assign wdata_o = ctrl_i.wsel_t ? t_q : w0_q;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: biquad cascade decimator
// Streams Q24.8 samples through the block while stepping decimation factor and
// hop length over their extremes over APB, and checks every filtered word
// against a bit-exact cascade and decimation predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  typedef logic signed [bqd_pkg::SAMPLE_WIDTH-1:0] sample_t;

  localparam sample_t SAMPLE_MAX   = {1'b0, {(bqd_pkg::SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN   = {1'b1, {(bqd_pkg::SAMPLE_WIDTH-1){1'b0}}};
  localparam int      DRAIN_CYCLES = 12 * bqd_pkg::SECTION_COUNT + 40;
  localparam int      CYCLE_LIMIT  = 400000;
  localparam int      HOLD_CYCLES  = 400;
  localparam int      HOLD_AFTER   = 20;
  localparam int      CALM_FROM    = 15000;
  localparam int      CALM_TO      = 27000;
  localparam int      RANDOM_ITEMS = 750;
  localparam longint  GAIN_Q       = 282333;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  sample_t                        sample_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  sample_t                        filtered_sample_o;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [bqd_pkg::PADDR_W-1:0]    paddr = '0;
  logic [bqd_pkg::PDATA_W-1:0]    pwdata = '0;
  logic [bqd_pkg::PDATA_W-1:0]    prdata;
  logic                           pready;

  // predictor state
  longint                         sec_w0 [bqd_pkg::SECTION_COUNT];
  longint                         sec_w1 [bqd_pkg::SECTION_COUNT];
  logic [bqd_pkg::DECIM_W-1:0]    decim_reg;
  logic [bqd_pkg::HOP_W-1:0]      hop_reg;
  int unsigned                    hop_pos;
  int unsigned                    decim_phase;

  sample_t                        sample_q [$];
  sample_t                        filtered_q [$];
  sample_t                        want_word;

  int                             cycles = 0;
  int                             errors = 0;
  int                             results_seen = 0;
  int                             samples_taken = 0;
  int                             items_queued = 0;
  int                             settings_used = 0;
  int                             hold_left = 0;
  logic                           hold_done = 1'b0;
  logic                           word_in;
  logic                           calm;

  assign calm = (cycles >= CALM_FROM) && (cycles < CALM_TO);

  biquad_cascade_decimator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .filtered_sample_o (filtered_sample_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint clamp(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // round half up to Q.8, then saturate to the state range
  function automatic longint round_q8(input longint v);
    return clamp((v + (64'sd1 <<< (bqd_pkg::COEF_FRAC - 1))) >>> bqd_pkg::COEF_FRAC,
                 bqd_pkg::STATE_W);
  endfunction

  function automatic longint section_coef(input int sec, input bqd_pkg::coef_sel_e sel);
    longint b1;
    longint a1;
    longint a2;
    case (sec)
      0: begin
        b1 = 1257059;  a1 = -1515472; a2 = 572939;
      end
      1: begin
        b1 = -595026;  a1 = -1496024; a2 = 715143;
      end
      2: begin
        b1 = -1152449; a1 = -1476662; a2 = 868920;
      end
      3: begin
        b1 = -1327336; a1 = -1468960; a2 = 968918;
      end
      default: begin
        b1 = -1382913; a1 = -1476649; a2 = 1026532;
      end
    endcase
    case (sel)
      bqd_pkg::CS_B1: return b1;
      bqd_pkg::CS_A1: return a1;
      bqd_pkg::CS_A2: return a2;
      default:        return GAIN_Q;
    endcase
  endfunction

  task automatic filter_sample(input sample_t smp);
    longint      x;
    longint      t;
    longint      u;
    longint      w0;
    longint      w1;
    int unsigned factor;
    int unsigned hop;
    bit          keep;
    factor = (decim_reg == 0) ? 1 :
             (decim_reg > bqd_pkg::DECIM_MAX) ? bqd_pkg::DECIM_MAX : decim_reg;
    hop    = (hop_reg == 0) ? 1 :
             (hop_reg > bqd_pkg::HOP_MAX) ? bqd_pkg::HOP_MAX : hop_reg;
    x = clamp(longint'(smp), bqd_pkg::STATE_W);
    for (int s = 0; s < bqd_pkg::SECTION_COUNT; s++) begin
      w0 = sec_w0[s];
      w1 = sec_w1[s];
      t = round_q8((x <<< bqd_pkg::COEF_FRAC) - section_coef(s, bqd_pkg::CS_A1) * w0
                   - section_coef(s, bqd_pkg::CS_A2) * w1);
      u = round_q8((t <<< bqd_pkg::COEF_FRAC) + section_coef(s, bqd_pkg::CS_B1) * w0
                   + (w1 <<< bqd_pkg::COEF_FRAC));
      x = round_q8(GAIN_Q * u);
      sec_w1[s] = w0;
      sec_w0[s] = t;
    end
    keep = (decim_phase == 0);
    decim_phase++;
    if (decim_phase >= factor) decim_phase = 0;
    hop_pos++;
    if (hop_pos >= hop) begin
      hop_pos = 0;
      decim_phase = 0;
    end
    decim_phase = decim_phase & 32'h7;
    hop_pos = hop_pos & 32'hFFF;
    if (keep) filtered_q.push_back(sample_t'(clamp(x, bqd_pkg::SAMPLE_WIDTH)));
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0, 1, 2, 3: return sample_t'($signed($urandom) >>> 10);
      4, 5:       return sample_t'($urandom);
      6:          return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      7:          return sample_t'(int'($urandom_range(511)) - 256);
      default:    return sample_t'($signed($urandom) >>> 20);
    endcase
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
    end else begin
      word_in = in_valid_i && in_ready_o;
      if (word_in) begin
        filter_sample(sample_i);
        samples_taken++;
      end
      if (word_in || !in_valid_i) begin
        if (sample_q.size() != 0 && (calm || hold_left != 0 || $urandom_range(99) >= 30)) begin
          in_valid_i <= 1'b1;
          sample_i   <= sample_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 30);
    end
  end

  // checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (filtered_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: got %0d", filtered_sample_o);
      end else begin
        want_word = filtered_q.pop_front();
        if (filtered_sample_o !== want_word) begin
          errors++;
          if (errors <= 10)
            $display("filtered_sample mismatch: expected %0d got %0d",
                     want_word, filtered_sample_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic apb_write(input bqd_pkg::reg_idx_e idx,
                           input logic [bqd_pkg::PDATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      bqd_pkg::REG_DECIM: decim_reg = data[bqd_pkg::DECIM_W-1:0];
      default:            hop_reg   = data[bqd_pkg::HOP_W-1:0];
    endcase
  endtask

  task automatic configure(input logic [bqd_pkg::DECIM_W-1:0] factor,
                           input logic [bqd_pkg::HOP_W-1:0] hop);
    apb_write(bqd_pkg::REG_DECIM, bqd_pkg::PDATA_W'(factor));
    apb_write(bqd_pkg::REG_HOP, bqd_pkg::PDATA_W'(hop));
    settings_used++;
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) sample_q.push_back(random_sample());
    items_queued += n;
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    for (int s = 0; s < bqd_pkg::SECTION_COUNT; s++) begin
      sec_w0[s] = 0;
      sec_w1[s] = 0;
    end
    hop_pos     = 0;
    decim_phase = 0;
    decim_reg   = bqd_pkg::DECIM_RST;
    hop_reg     = bqd_pkg::HOP_RST;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);

    // directed: extremes, impulses, saturating steps, bit patterns
    sample_q.push_back('0);
    sample_q.push_back(SAMPLE_MAX);
    sample_q.push_back(SAMPLE_MIN);
    sample_q.push_back(sample_t'(1));
    sample_q.push_back(sample_t'(-1));
    sample_q.push_back(sample_t'(256));
    sample_q.push_back(sample_t'(-256));
    repeat (6) sample_q.push_back(SAMPLE_MAX);
    repeat (6) sample_q.push_back(SAMPLE_MIN);
    sample_q.push_back(sample_t'(32'h5555_5555));
    sample_q.push_back(sample_t'(32'hAAAA_AAAA));
    sample_q.push_back('0);
    sample_q.push_back('0);
    items_queued += 23;
    drain();

    configure(4'd1, 13'd1);
    queue_random(80);
    drain();
    configure(4'd0, 13'd0);
    queue_random(40);
    drain();
    configure(bqd_pkg::DECIM_MAX, bqd_pkg::HOP_MAX);
    queue_random(100);
    drain();
    configure(4'd15, 13'd8191);
    queue_random(60);
    drain();
    configure(4'd3, 13'd7);
    queue_random(100);
    drain();
    configure(4'd5, 13'd3);
    queue_random(60);
    drain();

    while (items_queued < RANDOM_ITEMS + 23) begin
      case ($urandom_range(19))
        0:       configure(4'($urandom_range(15)), 13'($urandom_range(4097, 8191)));
        1, 2, 3: configure(4'($urandom_range(15)), 13'($urandom_range(41, 300)));
        default: configure(4'($urandom_range(15)), 13'($urandom_range(0, 40)));
      endcase
      queue_random($urandom_range(30, 70));
      drain();
    end

    errors += filtered_q.size();
    $display("Checked %0d filtered words from %0d samples over %0d register settings,",
             results_seen, samples_taken, settings_used + 1);
    $display("including a %0d-cycle output stall that backed up the input.", HOLD_CYCLES);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
